// ----- rtl/sprite_cull_band_budget_core_defines.svh -----
// Assertion macros shared by the sprite cull core.
`ifndef SPRITE_CULL_BAND_BUDGET_CORE_DEFINES_SVH
`define SPRITE_CULL_BAND_BUDGET_CORE_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SCBB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define SCBB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/scbb_pkg.sv -----
`timescale 1ns / 1ps

package scbb_pkg;

  // Table size per frame
  localparam int unsigned MaxEntries = 80;
  localparam int unsigned EntryW     = $clog2(MaxEntries + 1);
  localparam int unsigned SlotW      = 7;

  // Item commands
  typedef enum logic [1:0] {
    CmdFrame  = 2'd0,
    CmdObject = 2'd1,
    CmdPiece  = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [3:0] {
    CfgCamera     = 4'd0,
    CfgBandSelect = 4'd1,
    CfgCountCap   = 4'd2,
    CfgWidthCap   = 4'd3,
    CfgDxLow      = 4'd4,
    CfgDxHigh     = 4'd5,
    CfgDyLow      = 4'd6,
    CfgDyHigh     = 4'd7
  } cfg_reg_e;

  // Object flag bit positions
  localparam int unsigned FlagHide    = 7;
  localparam int unsigned FlagScreen  = 6;
  localparam int unsigned FlagBlink   = 5;
  localparam int unsigned FlagBlinked = 4;
  localparam int unsigned FlagAdjust  = 2;
  localparam int unsigned FlagBudget  = 1;

  // Screen window and band layout
  localparam logic signed [19:0] ClipXMax   = 20'sh001BF;
  localparam logic signed [19:0] ClipYMax   = 20'sh0015F;
  localparam logic signed [19:0] ScreenEdge = 20'sh00080;
  localparam logic signed [19:0] BandBase   = 20'sh00060;
  localparam logic signed [19:0] BandFirst  = 20'sh00061;
  localparam logic signed [17:0] OriginBias = 18'sh00080;

  // Attribute merge masks
  localparam logic [15:0] AttrKeep  = 16'h9FFF;
  localparam logic [15:0] AttrHigh  = 16'hF800;
  localparam logic [15:0] AttrPrio  = 16'h6000;

  typedef struct packed {
    logic [1:0]          command;
    logic [7:0]          object_flags;
    logic [7:0]          blink_count;
    logic signed [15:0]  position_first;
    logic signed [15:0]  position_second;
    logic [2:0]          adjust_index;
    logic [4:0]          attr_high;
    logic signed [15:0]  piece_width;
    logic signed [15:0]  piece_height;
    logic signed [15:0]  piece_y_offset;
    logic signed [15:0]  piece_x_offset;
    logic [31:0]         piece_words;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  slot;
    logic [9:0]  sprite_y;
    logic [8:0]  sprite_x;
    logic [15:0] size_word;
    logic [15:0] sprite_attr;
  } out_item_t;

endpackage

// ----- rtl/sprite_cull_band_budget_core.sv -----
`timescale 1ns / 1ps
// Sprite table builder: takes one word per cycle (frame start, object header or
// piece) and answers a surviving piece with one table entry in the cycle after it
// is accepted, through a single output register; the input stalls only while
// that register is full and the output is stalled. An object header sets the
// visibility and screen origin used by the pieces that follow it; each piece is
// clipped, counted into its 32-line band (count and width, wrapping at 8 bits)
// and may be dropped by that band's budget. At most 80 entries per frame, then
// pieces are ignored until the next frame start. Configuration writes are
// always taken (ready is tied high) and must only be made while the core is
// idle; indexes 8 to 15 are ignored.

`include "sprite_cull_band_budget_core_defines.svh"

module sprite_cull_band_budget_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  scbb_pkg::in_item_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output scbb_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  // Configuration registers
  logic [31:0] camera_q;
  logic [63:0] band_sel_q, count_cap_q, width_cap_q;
  logic [63:0] dx_lo_q, dx_hi_q, dy_lo_q, dy_hi_q;

  // Frame and object state
  logic [7:0]                  band_cnt_q [8];
  logic [7:0]                  band_wid_q [8];
  logic [scbb_pkg::EntryW-1:0] entry_cnt_q;
  logic                        visible_q;
  logic [7:0]                  flags_q;
  logic signed [17:0]          origin_x_q, origin_y_q;
  logic [4:0]                  attr_hi_q;

  // Output register
  logic                out_valid_q;
  scbb_pkg::out_item_t out_data_q;

  logic in_fire, is_frame, is_object, is_piece;
  logic emit;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign is_frame    = in_fire & (in_data_i.command == scbb_pkg::CmdFrame);
  assign is_object   = in_fire & (in_data_i.command == scbb_pkg::CmdObject);
  assign is_piece    = in_fire & (in_data_i.command == scbb_pkg::CmdPiece);

  // Configuration write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_q    <= '0;
      band_sel_q  <= '0;
      count_cap_q <= '0;
      width_cap_q <= '0;
      dx_lo_q     <= '0;
      dx_hi_q     <= '0;
      dy_lo_q     <= '0;
      dy_hi_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        scbb_pkg::CfgCamera:     camera_q    <= cfg_data_i[31:0];
        scbb_pkg::CfgBandSelect: band_sel_q  <= cfg_data_i;
        scbb_pkg::CfgCountCap:   count_cap_q <= cfg_data_i;
        scbb_pkg::CfgWidthCap:   width_cap_q <= cfg_data_i;
        scbb_pkg::CfgDxLow:      dx_lo_q     <= cfg_data_i;
        scbb_pkg::CfgDxHigh:     dx_hi_q     <= cfg_data_i;
        scbb_pkg::CfgDyLow:      dy_lo_q     <= cfg_data_i;
        scbb_pkg::CfgDyHigh:     dy_hi_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Object header: visibility
  logic vis_d;
  always_comb begin
    priority if (in_data_i.object_flags[scbb_pkg::FlagHide]) begin
      vis_d = 1'b0;
    end else if (!in_data_i.object_flags[scbb_pkg::FlagBlink]) begin
      vis_d = 1'b1;
    end else if (in_data_i.object_flags[scbb_pkg::FlagBlinked]) begin
      vis_d = (in_data_i.blink_count == 8'd0);
    end else begin
      vis_d = (in_data_i.blink_count != 8'd0);
    end
  end

  // Object header: origin
  logic [63:0]        adj_x_word, adj_y_word;
  logic signed [15:0] adj_x, adj_y, cam_x, cam_y;
  logic signed [17:0] world_x, world_y, origin_x_d, origin_y_d;
  always_comb begin
    adj_x_word = in_data_i.adjust_index[2] ? dx_hi_q : dx_lo_q;
    adj_y_word = in_data_i.adjust_index[2] ? dy_hi_q : dy_lo_q;
    adj_x      = adj_x_word[{in_data_i.adjust_index[1:0], 4'd0} +: 16];
    adj_y      = adj_y_word[{in_data_i.adjust_index[1:0], 4'd0} +: 16];
    cam_x      = camera_q[15:0];
    cam_y      = camera_q[31:16];
    world_x    = $signed({5'd0, in_data_i.position_second[15:3]}) - 18'(cam_x);
    world_y    = $signed({5'd0, in_data_i.position_first[15:3]}) - 18'(cam_y);
    if (in_data_i.object_flags[scbb_pkg::FlagAdjust]) begin
      world_x = world_x + 18'(adj_x);
      world_y = world_y + 18'(adj_y);
    end
    if (in_data_i.object_flags[scbb_pkg::FlagScreen]) begin
      origin_x_d = 18'(in_data_i.position_first) + scbb_pkg::OriginBias;
      origin_y_d = 18'(in_data_i.position_second) + scbb_pkg::OriginBias;
    end else begin
      origin_x_d = world_x + scbb_pkg::OriginBias;
      origin_y_d = world_y + scbb_pkg::OriginBias;
    end
  end

  // Piece: position and clipping
  logic signed [19:0] px, py, band_rel;
  logic               room, on_screen, in_band;
  logic [2:0]         bi;
  always_comb begin
    px        = 20'(origin_x_q) + 20'(in_data_i.piece_x_offset);
    py        = 20'(origin_y_q) + 20'(in_data_i.piece_y_offset);
    band_rel  = py - scbb_pkg::BandBase;
    bi        = band_rel[7:5];
    room      = visible_q && (32'(entry_cnt_q) < scbb_pkg::MaxEntries);
    on_screen = !(px > scbb_pkg::ClipXMax) && !(py > scbb_pkg::ClipYMax)
                && !((px + 20'(in_data_i.piece_width)) < scbb_pkg::ScreenEdge)
                && !((py + 20'(in_data_i.piece_height)) < scbb_pkg::ScreenEdge);
    in_band   = (py >= scbb_pkg::BandFirst);
  end

  // Piece: band counters and budget
  logic [7:0] cnt_new, wid_new, sel_b, cap_n, cap_w;
  logic       keep;
  always_comb begin
    cnt_new = band_cnt_q[bi] + 8'd1;
    wid_new = band_wid_q[bi] + in_data_i.piece_width[10:3];
    sel_b   = band_sel_q[{bi, 3'd0} +: 8];
    cap_n   = count_cap_q[{bi, 3'd0} +: 8];
    cap_w   = width_cap_q[{bi, 3'd0} +: 8];
    priority if (!flags_q[scbb_pkg::FlagBudget] || sel_b == 8'd0 || !in_band) begin
      keep = 1'b1;
    end else if (!sel_b[7]) begin
      keep = !(cnt_new <= cap_n || wid_new <= cap_w);
    end else if (cnt_new <= cap_n || wid_new <= cap_w) begin
      keep = 1'b1;
    end else begin
      keep = !({cap_n[6:0], 1'b0} >= cnt_new) && !({cap_w[6:0], 1'b0} >= wid_new);
    end
  end

  logic band_upd;
  assign band_upd = is_piece & room & on_screen & in_band;
  assign emit     = is_piece & room & on_screen & keep;

  // Piece: merged attribute
  logic [15:0] attr_in, attr_v;
  always_comb begin
    attr_in = in_data_i.piece_words[15:0];
    attr_v  = (attr_in & scbb_pkg::AttrKeep)
              ^ ({attr_hi_q, 11'd0} & scbb_pkg::AttrHigh);
    if ((attr_in & scbb_pkg::AttrPrio) != 16'd0) begin
      attr_v = (attr_v & scbb_pkg::AttrKeep) | attr_in;
    end
  end

  // Frame and object state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        band_cnt_q[i] <= '0;
        band_wid_q[i] <= '0;
      end
      entry_cnt_q <= '0;
      visible_q   <= 1'b0;
      flags_q     <= '0;
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      attr_hi_q   <= '0;
    end else begin
      if (is_frame) begin
        for (int i = 0; i < 8; i++) begin
          band_cnt_q[i] <= '0;
          band_wid_q[i] <= '0;
        end
        entry_cnt_q <= '0;
      end
      if (is_object) begin
        visible_q  <= vis_d;
        flags_q    <= in_data_i.object_flags;
        origin_x_q <= origin_x_d;
        origin_y_q <= origin_y_d;
        attr_hi_q  <= in_data_i.attr_high;
      end
      if (band_upd) begin
        band_cnt_q[bi] <= cnt_new;
        band_wid_q[bi] <= wid_new;
      end
      if (emit) begin
        entry_cnt_q <= entry_cnt_q + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= emit | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.slot        <= scbb_pkg::SlotW'(entry_cnt_q);
      out_data_q.sprite_y    <= py[9:0];
      out_data_q.sprite_x    <= px[8:0];
      out_data_q.size_word   <= in_data_i.piece_words[31:16];
      out_data_q.sprite_attr <= attr_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  `SCBB_ASSERT_ALWAYS(a_stall_needs_word, in_stall_o |-> out_valid_o, "stall without a held word")
  `SCBB_ASSERT(a_table_bound, 32'(entry_cnt_q) <= scbb_pkg::MaxEntries, "entry count over table size")
  `SCBB_ASSERT(a_emit_counts, emit |=> (entry_cnt_q == $past(entry_cnt_q) + 1'b1), "emit without count step")
  `SCBB_ASSERT(a_frame_clears, is_frame |=> (entry_cnt_q == '0) && !out_valid_o, "frame start left state")

endmodule
